// ===== hw/rtl/prf_pkg.sv =====
// Shared types, codes and constants of the prime and safe prime finder.
`default_nettype none
package prf_pkg;

   localparam int VALUE_BITS_DEFAULT = 31;
   localparam int VALUE_WIDTH        = 31;
   localparam int NUM_WIDTH          = 32;
   localparam int DIV_WIDTH          = 17;
   localparam int SMALL_COUNT        = 9;
   localparam int SMALL_IDX_WIDTH    = 4;

   localparam logic [1:0] FUNC_TEST = 2'd0;
   localparam logic [1:0] FUNC_NEXT = 2'd1;
   localparam logic [1:0] FUNC_SAFE = 2'd2;

   localparam logic [SMALL_IDX_WIDTH-1:0] LAST_SMALL_IDX = SMALL_IDX_WIDTH'(SMALL_COUNT - 1);
   localparam logic [4:0] SMALL_PRIMES [SMALL_COUNT] =
      '{5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23};
   localparam logic [DIV_WIDTH-1:0] FIRST_LARGE_DIV = 17'd29;
   localparam logic [NUM_WIDTH:0]   FIRST_LARGE_SQ  = 33'd841;

   typedef enum logic [2:0] {
      T_IDLE,
      T_SMALL,
      T_SMALL_WAIT,
      T_LARGE,
      T_LARGE_WAIT
   } test_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_WAIT,
      S_SAFE_CHECK,
      S_SAFE_WAIT,
      S_FINISH
   } search_state_type;

   typedef struct packed {
      logic                 start;
      logic [NUM_WIDTH-1:0] dividend;
      logic [DIV_WIDTH-1:0] divisor;
   } prf_div_req_type;

   typedef struct packed {
      logic done;
      logic zero;
   } prf_div_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [NUM_WIDTH-1:0] number;
   } prf_test_req_type;

   typedef struct packed {
      logic done;
      logic prime;
   } prf_test_rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/prf_serial_mod.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module prf_serial_mod (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire prf_pkg::prf_div_req_type div_req,
   output      prf_pkg::prf_div_rsp_type div_rsp
);
   import prf_pkg::*;

   localparam int CNT_WIDTH = $clog2(NUM_WIDTH);
   localparam logic [CNT_WIDTH-1:0] LAST_BIT = CNT_WIDTH'(NUM_WIDTH - 1);

   logic                 busy_ff, busy_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] shift_ff, shift_in;
   logic [DIV_WIDTH-1:0] div_ff, div_in;
   logic [DIV_WIDTH-1:0] rem_ff, rem_in;
   logic [DIV_WIDTH:0]   rem_sh;
   logic                 fits;

   always_comb begin
      rem_sh = {rem_ff, shift_ff[NUM_WIDTH-1]};
      fits   = rem_sh >= {1'b0, div_ff};
      rem_in = fits ? DIV_WIDTH'(rem_sh - {1'b0, div_ff}) : rem_sh[DIV_WIDTH-1:0];
   end

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      if (busy_ff) begin
         shift_in = {shift_ff[NUM_WIDTH-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == LAST_BIT) begin
            busy_in = 1'b0;
         end
      end else if (div_req.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = div_req.dividend;
         div_in   = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      div_ff   <= div_in;
      if (busy_ff) begin
         rem_ff <= rem_in;
      end else begin
         rem_ff <= '0;
      end
   end

   assign div_rsp.done = busy_ff && (cnt_ff == LAST_BIT);
   assign div_rsp.zero = rem_in == '0;

endmodule
`default_nettype wire

// ===== hw/rtl/prf_trial_test.sv =====
// Trial-division primality test of one candidate over the serial remainder unit.
`default_nettype none
module prf_trial_test (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire prf_pkg::prf_test_req_type test_req,
   output      prf_pkg::prf_test_rsp_type test_rsp
);
   import prf_pkg::*;

   test_state_type state_ff, state_in;

   logic [NUM_WIDTH-1:0]       n_ff;
   logic [SMALL_IDX_WIDTH-1:0] idx_ff;
   logic [DIV_WIDTH-1:0]       d_ff;
   logic [NUM_WIDTH:0]         sq_ff;
   logic                       below_two;
   logic                       is_small;
   logic                       past_root;
   prf_div_req_type            div_req;
   prf_div_rsp_type            div_rsp;

   prf_serial_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      below_two = n_ff < NUM_WIDTH'(2);
      is_small  = n_ff == NUM_WIDTH'(SMALL_PRIMES[idx_ff]);
      past_root = sq_ff > {1'b0, n_ff};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE: begin
            if (test_req.start) state_in = T_SMALL;
         end
         T_SMALL: begin
            if (below_two || is_small) state_in = T_IDLE;
            else                       state_in = T_SMALL_WAIT;
         end
         T_SMALL_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.zero)                 state_in = T_IDLE;
               else if (idx_ff == LAST_SMALL_IDX) state_in = T_LARGE;
               else                               state_in = T_SMALL;
            end
         end
         T_LARGE: begin
            if (past_root) state_in = T_IDLE;
            else           state_in = T_LARGE_WAIT;
         end
         T_LARGE_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.zero) state_in = T_IDLE;
               else              state_in = T_LARGE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = n_ff;
      div_req.divisor  = d_ff;
      test_rsp.done    = 1'b0;
      test_rsp.prime   = 1'b0;
      case (state_ff)
         T_SMALL: begin
            div_req.divisor = DIV_WIDTH'(SMALL_PRIMES[idx_ff]);
            if (below_two) begin
               test_rsp.done = 1'b1;
            end else if (is_small) begin
               test_rsp.done  = 1'b1;
               test_rsp.prime = 1'b1;
            end else begin
               div_req.start = 1'b1;
            end
         end
         T_SMALL_WAIT, T_LARGE_WAIT: begin
            if (div_rsp.done && div_rsp.zero) test_rsp.done = 1'b1;
         end
         T_LARGE: begin
            if (past_root) begin
               test_rsp.done  = 1'b1;
               test_rsp.prime = 1'b1;
            end else begin
               div_req.start = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
      case (state_ff)
         T_IDLE: begin
            n_ff   <= test_req.number;
            idx_ff <= '0;
            d_ff   <= FIRST_LARGE_DIV;
            sq_ff  <= FIRST_LARGE_SQ;
         end
         T_SMALL_WAIT: begin
            if (div_rsp.done && idx_ff != LAST_SMALL_IDX) idx_ff <= idx_ff + 1'b1;
         end
         T_LARGE_WAIT: begin
            if (div_rsp.done) begin
               d_ff  <= d_ff + 1'b1;
               sq_ff <= sq_ff + {(NUM_WIDTH - DIV_WIDTH)'(0), d_ff, 1'b1};
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/prime_and_safe_prime_finder.sv =====
// Top level: primality test, next prime and next safe prime search.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tdata: value, tuser: func
//   rsp     | out | rsp_tvalid/rsp_tready | tdata: answer, tuser: prime_flag, overflow
//
// One trial division is a start request and 32 bit steps in the remainder unit. A candidate
// n is divided by the 9 small primes, then by each d >= 29 while d*d <= n; searches test
// candidate c, and 2c + 1 if c is prime in a safe search. Reset is synchronous and clears
// the control state. One transaction is worked on at a time; a finished result waits in the
// output register while the next transaction is accepted and computed.
`default_nettype none
module prime_and_safe_prime_finder #(
   parameter int VALUE_BITS = prf_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,  // [30:0] value
   input  wire logic [1:0]  req_tuser,  // [1:0] func
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,  // [31:0] answer
   output      logic [1:0]  rsp_tuser   // [0] prime_flag, [1] overflow
);
   import prf_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] VALUE_MASK =
      VALUE_WIDTH'((33'd1 << VALUE_BITS) - 33'd1);

   search_state_type state_ff, state_in;

   logic [1:0]             func_ff;
   logic [NUM_WIDTH:0]     cand_ff;
   logic [NUM_WIDTH-1:0]   half_ff;
   logic [NUM_WIDTH-1:0]   ans_ff;
   logic                   flag_ff;
   logic                   ovf_ff;
   logic                   out_valid_ff;
   logic [NUM_WIDTH-1:0]   out_data_ff;
   logic [1:0]             out_user_ff;
   logic [VALUE_WIDTH-1:0] value;
   logic                   accept;
   logic                   out_free;
   prf_test_req_type       test_req;
   prf_test_rsp_type       test_rsp;

   prf_trial_test u_test (
      .clock    (clock),
      .reset    (reset),
      .test_req (test_req),
      .test_rsp (test_rsp)
   );

   assign value    = req_tdata[VALUE_WIDTH-1:0] & VALUE_MASK;
   assign accept   = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser inside {FUNC_TEST, FUNC_NEXT, FUNC_SAFE}) begin
                  state_in = S_CHECK;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_CHECK: begin
            if (cand_ff[NUM_WIDTH]) state_in = S_FINISH;
            else                    state_in = S_WAIT;
         end
         S_WAIT: begin
            if (test_rsp.done) begin
               if (func_ff == FUNC_TEST)                          state_in = S_FINISH;
               else if (!test_rsp.prime)                          state_in = S_CHECK;
               else if (func_ff == FUNC_SAFE)                     state_in = S_SAFE_CHECK;
               else                                               state_in = S_FINISH;
            end
         end
         S_SAFE_CHECK: begin
            if (half_ff[NUM_WIDTH-1]) state_in = S_FINISH;
            else                      state_in = S_SAFE_WAIT;
         end
         S_SAFE_WAIT: begin
            if (test_rsp.done) begin
               if (test_rsp.prime) state_in = S_FINISH;
               else                state_in = S_CHECK;
            end
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      test_req.start  = 1'b0;
      test_req.number = cand_ff[NUM_WIDTH-1:0];
      case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_CHECK: test_req.start = !cand_ff[NUM_WIDTH];
         S_SAFE_CHECK: begin
            test_req.start  = !half_ff[NUM_WIDTH-1];
            test_req.number = {half_ff[NUM_WIDTH-2:0], 1'b1};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_FINISH && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      case (state_ff)
         S_IDLE: begin
            func_ff <= req_tuser;
            ans_ff  <= '0;
            flag_ff <= 1'b0;
            ovf_ff  <= 1'b0;
            case (req_tuser)
               FUNC_TEST: cand_ff <= {2'b00, value};
               FUNC_NEXT: cand_ff <= {2'b00, value} + 1'b1;
               FUNC_SAFE: cand_ff <= {3'b000, value[VALUE_WIDTH-1:1]} + 1'b1;
               default:   cand_ff <= '0;
            endcase
         end
         S_CHECK: begin
            if (cand_ff[NUM_WIDTH]) ovf_ff <= 1'b1;
         end
         S_WAIT: begin
            if (test_rsp.done) begin
               if (func_ff == FUNC_TEST) begin
                  ans_ff  <= cand_ff[NUM_WIDTH-1:0];
                  flag_ff <= test_rsp.prime;
               end else if (!test_rsp.prime) begin
                  cand_ff <= cand_ff + 1'b1;
               end else if (func_ff == FUNC_SAFE) begin
                  half_ff <= cand_ff[NUM_WIDTH-1:0];
               end else begin
                  ans_ff  <= cand_ff[NUM_WIDTH-1:0];
                  flag_ff <= 1'b1;
               end
            end
         end
         S_SAFE_CHECK: begin
            if (half_ff[NUM_WIDTH-1]) ovf_ff <= 1'b1;
         end
         S_SAFE_WAIT: begin
            if (test_rsp.done) begin
               if (test_rsp.prime) begin
                  ans_ff  <= {half_ff[NUM_WIDTH-2:0], 1'b1};
                  flag_ff <= 1'b1;
               end else begin
                  cand_ff <= {1'b0, half_ff} + 1'b1;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               out_data_ff <= ans_ff;
               out_user_ff <= {ovf_ff, flag_ff};
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/prf_checker.sv =====
// Port-level checks of the prime and safe prime finder, bound to the top level.
`default_nettype none
module prf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 32'd0 && !rsp_tuser[0])
      else $error("overflow result carries an answer or prime flag");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction accepted while one is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind prime_and_safe_prime_finder prf_checker u_prf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
